// ===== hdl/homogeneous_vertex_transform_core_defines.svh =====
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Concurrent assertion helpers shared by the vertex transform RTL.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define HVT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vertex transform check failed");
// Consequent that must hold in the cycle after the antecedent.
`define HVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex transform check failed");
`else
`define HVT_ASSERT(lbl, clk, rst, prop)
`define HVT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/hvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants: default widths, register indexes and reset matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvt_pkg;

   localparam int HVT_FRAC_BITS  = 16;
   localparam int HVT_DATA_WIDTH = 32;

   // Matrix coefficients are always 32-bit fixed point, two per register.
   localparam int HVT_COEF_WIDTH   = 32;
   localparam int HVT_REG_WIDTH    = 64;
   localparam int HVT_NUM_REGS     = 8;
   localparam int HVT_INDEX_WIDTH  = 3;

   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_X_ROW_LO = 3'd0;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_X_ROW_HI = 3'd1;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_Y_ROW_LO = 3'd2;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_Y_ROW_HI = 3'd3;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_Z_ROW_LO = 3'd4;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_Z_ROW_HI = 3'd5;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_W_ROW_LO = 3'd6;
   localparam logic [HVT_INDEX_WIDTH-1:0] HVT_REG_W_ROW_HI = 3'd7;

   // Identity matrix: 1.0 in Q16.16 placed in the low or high half.
   localparam logic [HVT_REG_WIDTH-1:0] HVT_ONE_LO = 64'h0000_0000_0001_0000;
   localparam logic [HVT_REG_WIDTH-1:0] HVT_ONE_HI = 64'h0001_0000_0000_0000;
   localparam logic [HVT_REG_WIDTH-1:0] HVT_ZERO   = 64'h0;

endpackage

// ===== hdl/homogeneous_vertex_transform_core.sv =====
// ----------------------------------------------------------------------------
// Homogeneous vertex transform core
// 4x4 matrix times vertex with optional perspective divide, saturating.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  req_      in         req_valid/req_ready    x, y, z, w, do_divide
//  rsp_      out        rsp_valid/rsp_ready    x, y, z, w, zero_divisor, saturated
//  csr_      in         csr_valid/csr_ready    matrix register index and data
//
// One request enters per clock while the output is not stalled.
// The restoring divider produces one quotient bit per stage.
// All stages advance together; a stalled output freezes the whole pipeline.
// Reset restores the identity matrix and empties the pipeline.
// csr_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "homogeneous_vertex_transform_core_defines.svh"

module homogeneous_vertex_transform_core #(
   parameter int FRAC_BITS  = hvt_pkg::HVT_FRAC_BITS,
   parameter int DATA_WIDTH = hvt_pkg::HVT_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [DATA_WIDTH-1:0]          req_in_x,
   input  logic signed [DATA_WIDTH-1:0]          req_in_y,
   input  logic signed [DATA_WIDTH-1:0]          req_in_z,
   input  logic signed [DATA_WIDTH-1:0]          req_in_w,
   input  logic                                  req_do_divide,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]          rsp_out_x,
   output logic signed [DATA_WIDTH-1:0]          rsp_out_y,
   output logic signed [DATA_WIDTH-1:0]          rsp_out_z,
   output logic signed [DATA_WIDTH-1:0]          rsp_out_w,
   output logic                                  rsp_zero_divisor,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hvt_pkg::HVT_INDEX_WIDTH-1:0]   csr_index,
   input  logic [hvt_pkg::HVT_REG_WIDTH-1:0]     csr_data
);
   import hvt_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int CW   = HVT_COEF_WIDTH;
   localparam int PW   = CW + DW;
   localparam int AW   = PW + 2;
   localparam int NW   = AW + FRAC_BITS;
   localparam int QW   = DW + 1;
   localparam int HW   = NW - QW;
   localparam int CMPW = (HW > AW) ? HW : AW;

   localparam logic [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic          ONE_SAT = (FRAC_BITS >= DW - 1);
   localparam logic [DW-1:0] ONE_OUT = ONE_SAT ? OUT_MAX : (DW'(1) << FRAC_BITS);

   logic en;

   // Matrix registers.
   logic [HVT_REG_WIDTH-1:0] mat_ff [0:HVT_NUM_REGS-1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[HVT_REG_X_ROW_LO] <= HVT_ONE_LO;
         mat_ff[HVT_REG_X_ROW_HI] <= HVT_ZERO;
         mat_ff[HVT_REG_Y_ROW_LO] <= HVT_ONE_HI;
         mat_ff[HVT_REG_Y_ROW_HI] <= HVT_ZERO;
         mat_ff[HVT_REG_Z_ROW_LO] <= HVT_ZERO;
         mat_ff[HVT_REG_Z_ROW_HI] <= HVT_ONE_LO;
         mat_ff[HVT_REG_W_ROW_LO] <= HVT_ZERO;
         mat_ff[HVT_REG_W_ROW_HI] <= HVT_ONE_HI;
      end else if (csr_valid && csr_ready) begin
         mat_ff[csr_index] <= csr_data;
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Stage 1: sixteen products.
   logic signed [DW-1:0] vin [0:3];
   logic signed [PW-1:0] prod_in [0:15];
   logic signed [PW-1:0] prod_ff [0:15];
   logic                 v1_ff, div1_ff;

   assign vin[0] = req_in_x;
   assign vin[1] = req_in_y;
   assign vin[2] = req_in_z;
   assign vin[3] = req_in_w;

   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         logic signed [CW-1:0] coef;
         assign coef = mat_ff[2*r + c/2][CW*(c%2) +: CW];
         assign prod_in[4*r+c] = coef * vin[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         div1_ff <= req_do_divide;
      end
   end

   // Stage 2: pair sums.
   logic signed [PW:0] pair_ff [0:7];
   logic               v2_ff, div2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            pair_ff[i] <= (PW+1)'(prod_ff[2*i]) + (PW+1)'(prod_ff[2*i+1]);
         end
         div2_ff <= div1_ff;
      end
   end

   // Stage 3: exact dot products.
   logic signed [AW-1:0] acc_ff [0:3];
   logic                 v3_ff, div3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= AW'(pair_ff[2*i]) + AW'(pair_ff[2*i+1]);
         end
         div3_ff <= div2_ff;
      end
   end

   // Divider pipeline: index 0 is loaded from stage 3, index QW feeds the output.
   logic            dv_ff    [0:QW];
   logic            ddiv_ff  [0:QW];
   logic            dzero_ff [0:QW];
   logic [AW-1:0]   dmag_ff  [0:QW];
   logic            dsat_ff  [0:QW];
   logic [DW-1:0]   dearly_ff[0:QW][0:3];
   logic            dneg_ff  [0:QW][0:2];
   logic            dovf_ff  [0:QW][0:2];
   logic [AW-1:0]   drem_ff  [0:QW][0:2];
   logic [QW-1:0]   dlow_ff  [0:QW][0:2];
   logic [QW-1:0]   dquo_ff  [0:QW][0:2];

   // Front of the divider: magnitudes, overflow check and the plain results.
   logic [AW-1:0]        mag    [0:3];
   logic [NW-1:0]        num    [0:2];
   logic [HW-1:0]        num_hi [0:2];
   logic signed [AW-1:0] shr    [0:3];
   logic                 inrng  [0:3];
   logic [DW-1:0]        plain  [0:3];
   logic [DW-1:0]        early_in [0:3];
   logic                 zero_in, sat_in;
   logic                 ovf_in [0:2];
   logic                 neg_in [0:2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i]   = acc_ff[i][AW-1] ? AW'(-acc_ff[i]) : AW'(acc_ff[i]);
         shr[i]   = acc_ff[i] >>> FRAC_BITS;
         inrng[i] = (shr[i][AW-1:DW-1] == '0) || (shr[i][AW-1:DW-1] == '1);
         plain[i] = inrng[i] ? shr[i][DW-1:0] : (shr[i][AW-1] ? OUT_MIN : OUT_MAX);
      end
      zero_in = (acc_ff[3] == '0);
      for (int k = 0; k < 3; k++) begin
         num[k]    = {mag[k], {FRAC_BITS{1'b0}}};
         num_hi[k] = num[k][NW-1:QW];
         ovf_in[k] = CMPW'(num_hi[k]) >= CMPW'(mag[3]);
         neg_in[k] = acc_ff[k][AW-1] ^ acc_ff[3][AW-1];
      end
      if (!div3_ff) begin
         for (int i = 0; i < 4; i++) begin
            early_in[i] = plain[i];
         end
         sat_in = !(inrng[0] && inrng[1] && inrng[2] && inrng[3]);
      end else begin
         // Zero divisor: each nonzero x, y, z goes to the bound that matches its sign; a zero one stays zero.
         sat_in = ONE_SAT;
         for (int k = 0; k < 3; k++) begin
            if (acc_ff[k] == '0) begin
               early_in[k] = '0;
            end else begin
               early_in[k] = acc_ff[k][AW-1] ? OUT_MIN : OUT_MAX;
               sat_in      = sat_in || zero_in;
            end
         end
         early_in[3] = ONE_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ddiv_ff[0]  <= div3_ff;
         dzero_ff[0] <= zero_in;
         dmag_ff[0]  <= mag[3];
         dsat_ff[0]  <= sat_in;
         for (int i = 0; i < 4; i++) begin
            dearly_ff[0][i] <= early_in[i];
         end
         for (int k = 0; k < 3; k++) begin
            dneg_ff[0][k] <= neg_in[k];
            dovf_ff[0][k] <= ovf_in[k];
            drem_ff[0][k] <= AW'(num_hi[k]);
            dlow_ff[0][k] <= num[k][QW-1:0];
            dquo_ff[0][k] <= '0;
         end
      end
   end

   // Restoring divider, one quotient bit per stage for each of x, y, z.
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [AW:0] trial [0:2];
      logic [AW:0] diff  [0:2];
      logic        take  [0:2];

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            trial[k] = {drem_ff[j][k], dlow_ff[j][k][QW-1]};
            diff[k]  = trial[k] - {1'b0, dmag_ff[j]};
            take[k]  = trial[k] >= {1'b0, dmag_ff[j]};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ddiv_ff[j+1]   <= ddiv_ff[j];
            dzero_ff[j+1]  <= dzero_ff[j];
            dmag_ff[j+1]   <= dmag_ff[j];
            dsat_ff[j+1]   <= dsat_ff[j];
            dearly_ff[j+1] <= dearly_ff[j];
            dneg_ff[j+1]   <= dneg_ff[j];
            dovf_ff[j+1]   <= dovf_ff[j];
            for (int k = 0; k < 3; k++) begin
               drem_ff[j+1][k] <= take[k] ? diff[k][AW-1:0] : trial[k][AW-1:0];
               dlow_ff[j+1][k] <= {dlow_ff[j][k][QW-2:0], 1'b0};
               dquo_ff[j+1][k] <= {dquo_ff[j][k][QW-2:0], take[k]};
            end
         end
      end
   end

   // Valid bits for every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i <= QW; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff[0] <= v3_ff;
         for (int i = 0; i < QW; i++) begin
            dv_ff[i+1] <= dv_ff[i];
         end
      end
   end

   // Output stage: sign, clamp and selection.
   logic [DW-1:0] out_in [0:3];
   logic          osat_in, ozero_in;
   logic [QW-1:0] q;
   logic          qsat;

   always_comb begin
      osat_in  = dsat_ff[QW];
      ozero_in = ddiv_ff[QW] && dzero_ff[QW];
      for (int i = 0; i < 4; i++) begin
         out_in[i] = dearly_ff[QW][i];
      end
      q    = '0;
      qsat = 1'b0;
      if (ddiv_ff[QW] && !dzero_ff[QW]) begin
         for (int k = 0; k < 3; k++) begin
            q = dquo_ff[QW][k];
            if (dneg_ff[QW][k]) begin
               qsat = dovf_ff[QW][k] || q[DW] || (q[DW-1] && (q[DW-2:0] != '0));
               out_in[k] = qsat ? OUT_MIN : DW'(-q[DW-1:0]);
            end else begin
               qsat = dovf_ff[QW][k] || (q[QW-1:DW-1] != '0);
               out_in[k] = qsat ? OUT_MAX : q[DW-1:0];
            end
            osat_in = osat_in || qsat;
         end
      end
   end

   logic          rsp_valid_ff;
   logic [DW-1:0] out_ff [0:3];
   logic          zero_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff  <= out_in;
         zero_ff <= ozero_in;
         sat_ff  <= osat_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_out_w        = out_ff[3];
   assign rsp_zero_divisor = zero_ff;
   assign rsp_saturated    = sat_ff;

   logic rsp_zdiv, rsp_xyz_zero, rem_live;

   assign rsp_zdiv     = rsp_valid && rsp_zero_divisor;
   assign rsp_xyz_zero = (rsp_out_x == '0) && (rsp_out_y == '0) && (rsp_out_z == '0);
   assign rem_live     = dv_ff[1] && ddiv_ff[1] && !dzero_ff[1] && !dovf_ff[1][0];

   // A zero divisor always returns w as one.
   `HVT_ASSERT(a_zero_div_w, clock, reset, !rsp_zdiv || (rsp_out_w == ONE_OUT))
   // A zero divisor with any nonzero x, y or z sum must report clamping.
   `HVT_ASSERT(a_zero_div_sat, clock, reset, !rsp_zdiv || rsp_saturated || rsp_xyz_zero)
   // The x partial remainder stays below the divisor once the divide is in range.
   `HVT_ASSERT(a_rem_bound, clock, reset, !rem_live || (drem_ff[1][0] < dmag_ff[1]))
   // A stalled divider stage keeps its request.
   `HVT_ASSERT_NEXT(a_stall_hold, clock, reset, dv_ff[0] && !en, dv_ff[0])

endmodule
